// ----- hw/rtl/blt_pkg.sv -----
// ============================================================================
// blt_pkg: shared definitions for the line tokenizer
// Token codes, character constants, keyword table and the token record type.
// ============================================================================
package blt_pkg;

  // Limits on run length, counting the character that trips the check, and on number value.
  localparam int MAX_ID_LENGTH  = 9;
  localparam int MAX_NUM_LENGTH = 12;
  localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

  // Depth of the token queue in front of the output port.
  localparam int QUEUE_DEPTH = 4;

  // Token kinds.
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_NEWLINE = 5'd1;
  localparam logic [4:0] K_WHITE   = 5'd2;
  localparam logic [4:0] K_ID      = 5'd3;
  localparam logic [4:0] K_NUMBER  = 5'd4;
  localparam logic [4:0] K_IF      = 5'd5;
  localparam logic [4:0] K_THEN    = 5'd6;
  localparam logic [4:0] K_ELSE    = 5'd7;
  localparam logic [4:0] K_ENDIF   = 5'd8;
  localparam logic [4:0] K_AND     = 5'd9;
  localparam logic [4:0] K_OR      = 5'd10;
  localparam logic [4:0] K_NOT     = 5'd11;
  localparam logic [4:0] K_GOTO    = 5'd12;
  localparam logic [4:0] K_PLUS    = 5'd13;
  localparam logic [4:0] K_MINUS   = 5'd14;
  localparam logic [4:0] K_MULT    = 5'd15;
  localparam logic [4:0] K_DIV     = 5'd16;
  localparam logic [4:0] K_MOD     = 5'd17;
  localparam logic [4:0] K_EQ      = 5'd18;
  localparam logic [4:0] K_NE      = 5'd19;
  localparam logic [4:0] K_LE      = 5'd20;
  localparam logic [4:0] K_GE      = 5'd21;
  localparam logic [4:0] K_LT      = 5'd22;
  localparam logic [4:0] K_GT      = 5'd23;
  localparam logic [4:0] K_LPAR    = 5'd24;
  localparam logic [4:0] K_RPAR    = 5'd25;
  localparam logic [4:0] K_COLON   = 5'd26;
  localparam logic [4:0] K_COMMA   = 5'd27;
  localparam logic [4:0] K_ILLEGAL = 5'd28;
  localparam logic [4:0] K_ID_LONG = 5'd29;
  localparam logic [4:0] K_NUM_OVF = 5'd30;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // One token as it leaves the block.
  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] number;
    logic [63:0] text;
    logic [3:0]  length;
  } token_t;

  // One queue entry: a token and the flag that closes the run of an item.
  typedef struct packed {
    token_t tok;
    logic   last;
  } entry_t;

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic logic is_id_start(input logic [7:0] ch);
    return (ch == CH_UNDER) || is_letter(ch);
  endfunction

  function automatic logic is_id_char(input logic [7:0] ch);
    return is_id_start(ch) || is_digit(ch);
  endfunction

  // Keyword text in lower case, first character in the low byte.
  function automatic logic [63:0] kw_text(input logic [2:0] idx);
    logic [63:0] t;
    case (idx)
      3'd0:    t = 64'h6669;        // if
      3'd1:    t = 64'h6E656874;    // then
      3'd2:    t = 64'h65736C65;    // else
      3'd3:    t = 64'h6669646E65;  // endif
      3'd4:    t = 64'h646E61;      // and
      3'd5:    t = 64'h726F;        // or
      3'd6:    t = 64'h746F6E;      // not
      default: t = 64'h6F746F67;    // goto
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_length(input logic [2:0] idx);
    logic [3:0] n;
    case (idx)
      3'd0:    n = 4'd2;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd3;
      3'd5:    n = 4'd2;
      3'd6:    n = 4'd3;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  // Identifier or keyword. Bytes past the length are zero in the buffer, so
  // a plain compare of the folded text against the padded keyword works.
  function automatic logic [4:0] classify_ident(input logic [63:0] text,
                                                input logic [3:0]  len);
    logic [63:0] low;
    logic [7:0]  ch;
    logic [4:0]  kind;
    low  = '0;
    kind = K_ID;
    for (int i = 0; i < 8; i++) begin
      ch = text[8*i +: 8];
      if ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) begin
        ch = ch | 8'h20;
      end
      low[8*i +: 8] = ch;
    end
    for (int k = 7; k >= 0; k--) begin
      if ((kw_length(3'(k)) == len) && (kw_text(3'(k)) == low)) begin
        kind = K_IF + 5'(k);
      end
    end
    return kind;
  endfunction

  // Kind of a character that forms a token on its own.
  function automatic logic [4:0] single_kind(input logic [7:0] ch);
    logic [4:0] kind;
    unique case (ch) inside
      CH_PLUS:          kind = K_PLUS;
      CH_MINUS:         kind = K_MINUS;
      CH_STAR:          kind = K_MULT;
      CH_SLASH:         kind = K_DIV;
      CH_PCT:           kind = K_MOD;
      CH_EQUAL:         kind = K_EQ;
      CH_LPAR:          kind = K_LPAR;
      CH_RPAR:          kind = K_RPAR;
      CH_COLON:         kind = K_COLON;
      CH_COMMA:         kind = K_COMMA;
      CH_SPACE, CH_TAB: kind = K_WHITE;
      default:          kind = K_ILLEGAL;
    endcase
    return kind;
  endfunction

endpackage

// ----- hw/rtl/basic_line_tokenizer.sv -----
// ============================================================================
// basic_line_tokenizer: streaming tokenizer for a small BASIC-like language
// Takes one source byte per transaction, or an end mark on tlast, and gives
// zero to two tokens per byte through a short token queue.
// ============================================================================
// Throughput: one byte per cycle while the queue has room for two tokens;
// the output port moves one token per cycle, so bytes that give two tokens
// drain at that rate through the 4-entry queue.
// Reset: synchronous, active high; scanning goes idle and the queue empties.
module basic_line_tokenizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
  input  logic         s_axis_tlast,   // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [4:0] token_kind, [35:5] number_value, [99:36] ident_text,
  // [103:100] ident_length
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tlast    // last_of_run
);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_NUMBER  = 3'd2;
  localparam logic [2:0] M_LT      = 3'd3;
  localparam logic [2:0] M_GT      = 3'd4;
  localparam logic [2:0] M_NEWLINE = 3'd5;
  localparam logic [2:0] M_COMMENT = 3'd6;

  localparam int PW = $clog2(blt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(blt_pkg::QUEUE_DEPTH + 1);

  // Scan state.
  logic [2:0]  mode, mode_next;
  logic [63:0] ident_buffer, ident_buffer_next;
  logic [3:0]  run_length, run_length_next;
  logic [30:0] number_accum, number_accum_next;
  logic        number_overflowed, number_overflowed_next;

  // Token queue.
  blt_pkg::entry_t queue [blt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count, count_next;

  logic        s_fire, m_fire;
  logic [7:0]  ch;
  logic        eot;
  logic [7:0]  digit_sub;
  logic [3:0]  digit;
  logic [34:0] accum_wide;
  logic        again;
  logic        clear;
  logic        pre_valid, post_valid;
  blt_pkg::token_t pre_tok, post_tok;
  blt_pkg::entry_t wr0, wr1;
  logic [1:0]  push_n;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign ch     = s_axis_tdata;
  assign eot    = s_axis_tlast;

  assign digit_sub  = ch - blt_pkg::CH_ZERO;
  assign digit      = digit_sub[3:0];
  // accum * 10 + digit as two shifts and adds.
  assign accum_wide = {number_accum, 3'b000} + {3'b000, number_accum, 1'b0}
                      + {31'd0, digit};

  always_comb begin
    mode_next              = mode;
    ident_buffer_next      = ident_buffer;
    run_length_next        = run_length;
    number_accum_next      = number_accum;
    number_overflowed_next = number_overflowed;
    again      = 1'b1;
    clear      = 1'b0;
    pre_valid  = 1'b0;
    pre_tok    = '0;
    post_valid = 1'b0;
    post_tok   = '0;

    // Finish or extend the token held in the state.
    unique case (mode)
      M_IDENT: begin
        if (!eot && blt_pkg::is_id_char(ch)) begin
          again = 1'b0;
          if (({1'b0, run_length} + 5'd1) >= 5'(blt_pkg::MAX_ID_LENGTH)) begin
            pre_valid    = 1'b1;
            pre_tok.kind = blt_pkg::K_ID_LONG;
            clear        = 1'b1;
          end else begin
            ident_buffer_next = ident_buffer
                                | ({56'd0, ch} << {run_length[2:0], 3'b000});
            run_length_next   = run_length + 4'd1;
          end
        end else begin
          pre_valid      = 1'b1;
          pre_tok.kind   = blt_pkg::classify_ident(ident_buffer, run_length);
          pre_tok.text   = ident_buffer;
          pre_tok.length = run_length;
          clear          = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!eot && blt_pkg::is_digit(ch)) begin
          again = 1'b0;
          if (({1'b0, run_length} + 5'd1) >= 5'(blt_pkg::MAX_NUM_LENGTH)) begin
            pre_valid    = 1'b1;
            pre_tok.kind = blt_pkg::K_NUM_OVF;
            clear        = 1'b1;
          end else begin
            if (accum_wide > {4'd0, blt_pkg::NUM_LIMIT}) begin
              number_overflowed_next = 1'b1;
            end else begin
              number_accum_next = accum_wide[30:0];
            end
            run_length_next = run_length + 4'd1;
          end
        end else begin
          pre_valid = 1'b1;
          if (number_overflowed) begin
            pre_tok.kind = blt_pkg::K_NUM_OVF;
          end else begin
            pre_tok.kind   = blt_pkg::K_NUMBER;
            pre_tok.number = number_accum;
          end
          clear = 1'b1;
        end
      end
      M_LT: begin
        pre_valid = 1'b1;
        if (!eot && (ch == blt_pkg::CH_GREAT)) begin
          pre_tok.kind = blt_pkg::K_NE;
          again        = 1'b0;
        end else if (!eot && (ch == blt_pkg::CH_EQUAL)) begin
          pre_tok.kind = blt_pkg::K_LE;
          again        = 1'b0;
        end else begin
          pre_tok.kind = blt_pkg::K_LT;
        end
        clear = 1'b1;
      end
      M_GT: begin
        pre_valid = 1'b1;
        if (!eot && (ch == blt_pkg::CH_EQUAL)) begin
          pre_tok.kind = blt_pkg::K_GE;
          again        = 1'b0;
        end else begin
          pre_tok.kind = blt_pkg::K_GT;
        end
        clear = 1'b1;
      end
      M_NEWLINE: begin
        if (!eot && ((ch == blt_pkg::CH_CR) || (ch == blt_pkg::CH_LF))) begin
          again = 1'b0;
        end else begin
          pre_valid    = 1'b1;
          pre_tok.kind = blt_pkg::K_NEWLINE;
          clear        = 1'b1;
        end
      end
      M_COMMENT: begin
        // Only LF or the end mark closes a comment; the LF is scanned again.
        if (!eot && (ch != blt_pkg::CH_LF)) begin
          again = 1'b0;
        end else begin
          clear = 1'b1;
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase

    if (clear) begin
      mode_next              = M_IDLE;
      ident_buffer_next      = '0;
      run_length_next        = '0;
      number_accum_next      = '0;
      number_overflowed_next = 1'b0;
    end

    // Start a new token with the current byte, or close the text.
    if (again) begin
      if (eot) begin
        post_valid    = 1'b1;
        post_tok.kind = blt_pkg::K_EOF;
      end else if (blt_pkg::is_id_start(ch)) begin
        mode_next         = M_IDENT;
        ident_buffer_next = {56'd0, ch};
        run_length_next   = 4'd1;
      end else if (blt_pkg::is_digit(ch)) begin
        mode_next              = M_NUMBER;
        number_accum_next      = {27'd0, digit};
        number_overflowed_next = 1'b0;
        run_length_next        = 4'd1;
      end else if ((ch == blt_pkg::CH_CR) || (ch == blt_pkg::CH_LF)) begin
        mode_next = M_NEWLINE;
      end else if (ch == blt_pkg::CH_LESS) begin
        mode_next = M_LT;
      end else if (ch == blt_pkg::CH_GREAT) begin
        mode_next = M_GT;
      end else if (ch == blt_pkg::CH_HASH) begin
        mode_next = M_COMMENT;
      end else begin
        post_valid    = 1'b1;
        post_tok.kind = blt_pkg::single_kind(ch);
      end
    end
  end

  // Queue writes: the first token of the item goes to the tail, a second
  // one behind it; the last one written carries the run flag.
  always_comb begin
    wr0.tok  = pre_valid ? pre_tok : post_tok;
    wr0.last = !(pre_valid && post_valid);
    wr1.tok  = post_tok;
    wr1.last = 1'b1;
    if (s_fire) begin
      push_n = {1'b0, pre_valid} + {1'b0, post_valid};
    end else begin
      push_n = 2'd0;
    end
    count_next = count + CW'(push_n) - CW'(m_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= M_IDLE;
      ident_buffer      <= '0;
      run_length        <= '0;
      number_accum      <= '0;
      number_overflowed <= 1'b0;
      head              <= '0;
      tail              <= '0;
      count             <= '0;
    end else begin
      if (s_fire) begin
        mode              <= mode_next;
        ident_buffer      <= ident_buffer_next;
        run_length        <= run_length_next;
        number_accum      <= number_accum_next;
        number_overflowed <= number_overflowed_next;
      end
      if (m_fire) begin
        head <= head + PW'(1);
      end
      tail  <= tail + PW'(push_n);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[tail] <= wr0;
    end
    if (push_n == 2'd2) begin
      queue[tail + PW'(1)] <= wr1;
    end
  end

  // Room for two tokens is kept so a byte never has to be split.
  assign s_axis_tready = (count <= CW'(blt_pkg::QUEUE_DEPTH - 2));
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {queue[head].tok.length, queue[head].tok.text,
                          queue[head].tok.number, queue[head].tok.kind};
  assign m_axis_tlast  = queue[head].last;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(blt_pkg::QUEUE_DEPTH))
    else $error("token queue count above its depth");

  a_drain_step : assert property (@(posedge clk) disable iff (rst)
    (m_fire && !s_fire) |=> (count == $past(count) - CW'(1)))
    else $error("token queue count did not drop after a pop");

  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    (mode == M_IDLE) |-> ((run_length == '0) && (number_accum == '0)
                          && (ident_buffer == '0)))
    else $error("scan state not cleared while idle");

  a_ident_len : assert property (@(posedge clk) disable iff (rst)
    (mode == M_IDENT) |-> ((run_length != '0)
                           && (run_length < 4'(blt_pkg::MAX_ID_LENGTH))))
    else $error("identifier length out of range");

  a_number_text : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[4:0] == blt_pkg::K_NUMBER))
      |-> (m_axis_tdata[103:36] == '0))
    else $error("number token carries identifier text");

endmodule
